@@ sv/mnrd_pkg.sv @@
package mnrd_pkg;

   // Width of the sample fields on the request channel.
   localparam int SAMPLE_FIELD_BITS = 16;

   // The ratio D/M is formed with 8 integer and 24 fraction bits.
   localparam int RATIO_INT_BITS  = 8;
   localparam int RATIO_FRAC_BITS = 24;
   localparam int RATIO_BITS      = RATIO_INT_BITS + RATIO_FRAC_BITS;
   localparam int ROOT_BITS       = RATIO_BITS / 2;
   localparam int STEP_CNT_BITS   = $clog2(RATIO_BITS);

   localparam logic [ROOT_BITS-1:0] NRMSD_MAX = '1;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_ROOT,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ sv/masked_normalized_rms_difference_unit.sv @@
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_sample_a, req_sample_b, req_in_mask,
//                                           req_last_sample
// rsp       out        rsp_valid/rsp_stall  rsp_nrmsd, rsp_result_valid
//
// The front end takes one sample pair per cycle while not stalled: one stage squares,
// the next accumulates. Each voxel's last item is queued (two voxels deep) for the back
// end, which runs 32 restoring division steps, 16 square-root steps, and handoff per
// voxel; an unmasked, zero-mean or saturating voxel skips the steps. Input stalls only
// when a last item finds the voxel queue full. Reset clears both sums and the queue.
module masked_normalized_rms_difference_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_a,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_b,
   input  logic                                         req_in_mask,
   input  logic                                         req_last_sample,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic [mnrd_pkg::ROOT_BITS-1:0]               rsp_nrmsd,
   output logic                                         rsp_result_valid
);
   import mnrd_pkg::*;

   localparam int MEAN_BITS = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES);
   localparam int DIFF_BITS = MEAN_BITS + 2;
   localparam int JOB_BITS  = MEAN_BITS + DIFF_BITS + 1;

   queue_status_type      queue_status;
   logic                  job_push;
   logic                  job_pop;
   logic [JOB_BITS-1:0]   push_data;
   logic [JOB_BITS-1:0]   pop_data;

   mnrd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MEAN_BITS   (MEAN_BITS),
      .DIFF_BITS   (DIFF_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_a    (req_sample_a),
      .req_sample_b    (req_sample_b),
      .req_in_mask     (req_in_mask),
      .req_last_sample (req_last_sample),
      .queue_status    (queue_status),
      .job_push        (job_push),
      .job_data        (push_data)
   );

   mnrd_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   mnrd_back #(
      .MEAN_BITS (MEAN_BITS),
      .DIFF_BITS (DIFF_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .job_data         (pop_data),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_nrmsd        (rsp_nrmsd),
      .rsp_result_valid (rsp_result_valid)
   );

endmodule

@@ sv/mnrd_front.sv @@
module mnrd_front #(
   parameter int SAMPLE_BITS = 16,
   parameter int MEAN_BITS   = 42,
   parameter int DIFF_BITS   = 44
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_a,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_b,
   input  logic                                         req_in_mask,
   input  logic                                         req_last_sample,
   input  mnrd_pkg::queue_status_type                   queue_status,
   output logic                                         job_push,
   output logic [MEAN_BITS+DIFF_BITS:0]                 job_data
);
   import mnrd_pkg::*;

   localparam int PW = (SAMPLE_BITS > SAMPLE_FIELD_BITS) ? SAMPLE_BITS : SAMPLE_FIELD_BITS;
   localparam int SQ_BITS = 2 * SAMPLE_BITS;

   logic [PW-1:0]             ext_a;
   logic [PW-1:0]             ext_b;
   logic signed [SAMPLE_BITS-1:0] val_a;
   logic signed [SAMPLE_BITS-1:0] val_b;
   logic signed [SAMPLE_BITS:0]   sum_s;
   logic signed [SAMPLE_BITS:0]   dif_s;
   logic [SAMPLE_BITS:0]      sum_mag;
   logic [SAMPLE_BITS:0]      dif_mag;
   logic [SQ_BITS+1:0]        sum_sq;
   logic [SQ_BITS+1:0]        dif_sq;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_mask_ff, s1_mask_in;
   logic                      s1_last_ff, s1_last_in;
   logic [SQ_BITS-1:0]        mean_inc_ff, mean_inc_in;
   logic [SQ_BITS-1:0]        diff_inc_ff, diff_inc_in;
   logic [MEAN_BITS-1:0]      mean_sum_ff, mean_sum_in;
   logic [DIFF_BITS-1:0]      diff_sum_ff, diff_sum_in;

   logic                      advance;
   logic                      accept;
   logic                      consume;
   logic [MEAN_BITS:0]        mean_wide;
   logic [DIFF_BITS:0]        diff_wide;
   logic [MEAN_BITS-1:0]      mean_new;
   logic [DIFF_BITS-1:0]      diff_new;

   // A finished voxel waits in the first stage while the queue is full.
   assign advance   = !(s1_valid_ff && s1_last_ff && queue_status.full);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign consume   = s1_valid_ff && advance;

   always_comb begin
      ext_a   = PW'($unsigned(req_sample_a));
      ext_b   = PW'($unsigned(req_sample_b));
      val_a   = signed'(ext_a[SAMPLE_BITS-1:0]);
      val_b   = signed'(ext_b[SAMPLE_BITS-1:0]);
      sum_s   = (SAMPLE_BITS+1)'(val_a) + (SAMPLE_BITS+1)'(val_b);
      dif_s   = (SAMPLE_BITS+1)'(val_a) - (SAMPLE_BITS+1)'(val_b);
      sum_mag = sum_s[SAMPLE_BITS] ? $unsigned(-sum_s) : $unsigned(sum_s);
      dif_mag = dif_s[SAMPLE_BITS] ? $unsigned(-dif_s) : $unsigned(dif_s);
      sum_sq  = sum_mag * sum_mag;
      dif_sq  = dif_mag * dif_mag;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_mask_in  = s1_mask_ff;
      s1_last_in  = s1_last_ff;
      mean_inc_in = mean_inc_ff;
      diff_inc_in = diff_inc_ff;
      if (advance) begin
         s1_valid_in = accept;
         s1_mask_in  = req_in_mask;
         s1_last_in  = req_last_sample;
         mean_inc_in = req_in_mask ? sum_sq[SQ_BITS+1:2] : '0;
         diff_inc_in = req_in_mask ? dif_sq[SQ_BITS-1:0] : '0;
      end
   end

   always_comb begin
      mean_wide = {1'b0, mean_sum_ff} + (MEAN_BITS+1)'(mean_inc_ff);
      diff_wide = {1'b0, diff_sum_ff} + (DIFF_BITS+1)'(diff_inc_ff);
      mean_new  = mean_wide[MEAN_BITS] ? '1 : mean_wide[MEAN_BITS-1:0];
      diff_new  = diff_wide[DIFF_BITS] ? '1 : diff_wide[DIFF_BITS-1:0];

      mean_sum_in = mean_sum_ff;
      diff_sum_in = diff_sum_ff;
      if (consume) begin
         mean_sum_in = s1_last_ff ? '0 : mean_new;
         diff_sum_in = s1_last_ff ? '0 : diff_new;
      end
      job_push = consume && s1_last_ff;
      job_data = {s1_mask_ff, mean_new, diff_new};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mean_sum_ff <= '0;
         diff_sum_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mean_sum_ff <= mean_sum_in;
         diff_sum_ff <= diff_sum_in;
      end
      s1_mask_ff  <= s1_mask_in;
      s1_last_ff  <= s1_last_in;
      mean_inc_ff <= mean_inc_in;
      diff_inc_ff <= diff_inc_in;
   end

endmodule

@@ sv/mnrd_queue.sv @@
module mnrd_queue #(
   parameter int WIDTH = 87
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output mnrd_pkg::queue_status_type status
);
   import mnrd_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic [WIDTH-1:0] entry_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in           = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
      pop_data     = entry_ff[rd_ptr_ff];
      status.full  = count_ff == 2'd2;
      status.empty = count_ff == 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      entry_ff <= entry_in;
   end

endmodule

@@ sv/mnrd_back.sv @@
module mnrd_back #(
   parameter int MEAN_BITS = 42,
   parameter int DIFF_BITS = 44
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mnrd_pkg::queue_status_type        queue_status,
   input  logic [MEAN_BITS+DIFF_BITS:0]      job_data,
   output logic                              job_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mnrd_pkg::ROOT_BITS-1:0]    rsp_nrmsd,
   output logic                              rsp_result_valid
);
   import mnrd_pkg::*;

   localparam logic [STEP_CNT_BITS-1:0] DIV_LAST  = STEP_CNT_BITS'(RATIO_BITS - 1);
   localparam logic [STEP_CNT_BITS-1:0] ROOT_LAST = STEP_CNT_BITS'(ROOT_BITS - 1);
   localparam int SREM_BITS = ROOT_BITS + 2;

   back_state_type          state_ff, state_in;
   logic [MEAN_BITS-1:0]    m_ff, m_in;
   logic [MEAN_BITS-1:0]    rem_ff, rem_in;
   logic [RATIO_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ROOT_BITS-1:0]    root_ff, root_in;
   logic [SREM_BITS-1:0]    srem_ff, srem_in;
   logic [ROOT_BITS-1:0]    res_value_ff, res_value_in;
   logic                    res_flag_ff, res_flag_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROOT_BITS-1:0]    rsp_nrmsd_ff, rsp_nrmsd_in;
   logic                    rsp_flag_ff, rsp_flag_in;

   logic                    job_mask;
   logic [MEAN_BITS-1:0]    job_m;
   logic [DIFF_BITS-1:0]    job_d;
   logic                    job_trivial;
   logic                    job_saturate;
   logic [MEAN_BITS+1:0]    div_diff;
   logic                    div_ge;
   logic [MEAN_BITS-1:0]    div_shift;
   logic [SREM_BITS-1:0]    sq_rem;
   logic [SREM_BITS:0]      sq_diff;
   logic                    sq_ge;
   logic [ROOT_BITS-1:0]    root_next;
   logic                    out_free;

   assign {job_mask, job_m, job_d} = job_data;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      job_trivial  = !job_mask || (job_m == '0);
      // The root reaches 16 or more exactly when D >= 256 * M.
      job_saturate = (MEAN_BITS+RATIO_INT_BITS)'(job_d) >= {job_m, {RATIO_INT_BITS{1'b0}}};

      // One restoring division step: the remainder stays below M.
      div_diff  = {1'b0, rem_ff, quo_ff[RATIO_BITS-1]} - {2'b00, m_ff};
      div_ge    = !div_diff[MEAN_BITS+1];
      div_shift = {rem_ff[MEAN_BITS-2:0], quo_ff[RATIO_BITS-1]};

      // One digit of the integer square root, two radicand bits a step.
      sq_rem    = {srem_ff[SREM_BITS-3:0], quo_ff[RATIO_BITS-1:RATIO_BITS-2]};
      sq_diff   = {1'b0, sq_rem} - {1'b0, root_ff, 2'b01};
      sq_ge     = !sq_diff[SREM_BITS];
      root_next = {root_ff[ROOT_BITS-2:0], sq_ge};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = (job_trivial || job_saturate) ? BK_DONE : BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = BK_ROOT;
            end
         end
         BK_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop      = 1'b0;
      m_in         = m_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      res_value_in = res_value_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_nrmsd_in = rsp_nrmsd_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty) begin
               job_pop      = 1'b1;
               m_in         = job_m;
               rem_in       = MEAN_BITS'(job_d[DIFF_BITS-1:RATIO_INT_BITS]);
               quo_in       = {job_d[RATIO_INT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
               cnt_in       = '0;
               res_flag_in  = !job_trivial;
               res_value_in = job_trivial ? '0 : NRMSD_MAX;
            end
         end
         BK_DIVIDE: begin
            rem_in  = div_ge ? div_diff[MEAN_BITS-1:0] : div_shift;
            quo_in  = {quo_ff[RATIO_BITS-2:0], div_ge};
            cnt_in  = cnt_ff + 1'b1;
            root_in = '0;
            srem_in = '0;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
            end
         end
         BK_ROOT: begin
            srem_in = sq_ge ? sq_diff[SREM_BITS-1:0] : sq_rem;
            root_in = root_next;
            quo_in  = {quo_ff[RATIO_BITS-3:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               res_value_in = root_next;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_nrmsd_in = res_value_ff;
               rsp_flag_in  = res_flag_ff;
            end
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_nrmsd        = rsp_nrmsd_ff;
   assign rsp_result_valid = rsp_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff         <= m_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      res_value_ff <= res_value_in;
      res_flag_ff  <= res_flag_in;
      rsp_nrmsd_ff <= rsp_nrmsd_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

@@ sim/nrmsd_checker.sv @@
module nrmsd_checker (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   input  logic                                          req_stall,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_a,
   input  logic signed [mnrd_pkg::SAMPLE_FIELD_BITS-1:0] req_sample_b,
   input  logic                                          req_in_mask,
   input  logic                                          req_last_sample,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   input  logic [mnrd_pkg::ROOT_BITS-1:0]                rsp_nrmsd,
   input  logic                                          rsp_result_valid,
   output int                                            failures,
   output int                                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEAN_SUM_BITS = 42;
   localparam int DIFF_SUM_BITS = 44;
   localparam logic [63:0] MEAN_SUM_MAX = (64'd1 << MEAN_SUM_BITS) - 64'd1;
   localparam logic [63:0] DIFF_SUM_MAX = (64'd1 << DIFF_SUM_BITS) - 64'd1;

   typedef struct packed {
      logic [mnrd_pkg::ROOT_BITS-1:0] nrmsd;
      logic                           result_valid;
   } voxel_result_type;

   voxel_result_type           voxel_results_q[$];
   logic [MEAN_SUM_BITS-1:0]   mean_square_acc = '0;
   logic [DIFF_SUM_BITS-1:0]   diff_square_acc = '0;
   int                         error_count = 0;

   function automatic logic [mnrd_pkg::ROOT_BITS-1:0] root_floor(
      input logic [mnrd_pkg::RATIO_BITS-1:0] x
   );
      logic [mnrd_pkg::ROOT_BITS-1:0] root;
      logic [mnrd_pkg::ROOT_BITS-1:0] trial;
      root = '0;
      for (int i = mnrd_pkg::ROOT_BITS - 1; i >= 0; i--) begin
         trial = root | (mnrd_pkg::ROOT_BITS'(1) << i);
         if (64'(trial) * 64'(trial) <= 64'(x)) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Result of a masked voxel from its two sums.
   function automatic voxel_result_type voxel_result(
      input logic [MEAN_SUM_BITS-1:0] mean_sum,
      input logic [DIFF_SUM_BITS-1:0] diff_sum
   );
      voxel_result_type result;
      logic [DIFF_SUM_BITS+mnrd_pkg::RATIO_FRAC_BITS-1:0] quotient;
      result = '0;
      if (mean_sum != '0) begin
         result.result_valid = 1'b1;
         // A ratio of 256 or more has a root of 16 or more, beyond Q4.12.
         if ((diff_sum >> 8) >= mean_sum) begin
            result.nrmsd = mnrd_pkg::NRMSD_MAX;
         end else begin
            quotient = {diff_sum, {mnrd_pkg::RATIO_FRAC_BITS{1'b0}}} /
                       (DIFF_SUM_BITS + mnrd_pkg::RATIO_FRAC_BITS)'(mean_sum);
            result.nrmsd = root_floor(quotient[mnrd_pkg::RATIO_BITS-1:0]);
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin : watch
      voxel_result_type want;
      longint           pair_sum;
      longint           pair_diff;
      logic [63:0]      mean_next;
      logic [63:0]      diff_next;
      if (reset) begin
         voxel_results_q.delete();
         mean_square_acc = '0;
         diff_square_acc = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (voxel_results_q.size() == 0) begin
               error_count++;
               $display("%0t: result with no voxel outstanding: expected none, %s %0d valid %0b",
                        $time, "got nrmsd", rsp_nrmsd, rsp_result_valid);
            end else begin
               want = voxel_results_q.pop_front();
               if (rsp_nrmsd !== want.nrmsd) begin
                  error_count++;
                  $display("%0t: nrmsd mismatch: expected %0d, got %0d",
                           $time, want.nrmsd, rsp_nrmsd);
               end
               if (rsp_result_valid !== want.result_valid) begin
                  error_count++;
                  $display("%0t: result_valid mismatch: expected %0b, got %0b",
                           $time, want.result_valid, rsp_result_valid);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_in_mask) begin
               pair_sum  = longint'(req_sample_a) + longint'(req_sample_b);
               pair_diff = longint'(req_sample_a) - longint'(req_sample_b);
               // The squared mean is (a+b)^2/4, rounded down.
               mean_next = 64'(mean_square_acc) + (64'(pair_sum * pair_sum) >> 2);
               diff_next = 64'(diff_square_acc) + 64'(pair_diff * pair_diff);
               mean_square_acc = (mean_next > MEAN_SUM_MAX) ? MEAN_SUM_MAX[MEAN_SUM_BITS-1:0]
                                                            : mean_next[MEAN_SUM_BITS-1:0];
               diff_square_acc = (diff_next > DIFF_SUM_MAX) ? DIFF_SUM_MAX[DIFF_SUM_BITS-1:0]
                                                            : diff_next[DIFF_SUM_BITS-1:0];
            end
            if (req_last_sample) begin
               want = '0;
               if (req_in_mask) begin
                  want = voxel_result(mean_square_acc, diff_square_acc);
               end
               voxel_results_q.push_back(want);
               mean_square_acc = '0;
               diff_square_acc = '0;
            end
         end
      end
      pending  <= voxel_results_q.size();
      failures <= error_count;
   end

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = mnrd_pkg::SAMPLE_FIELD_BITS;
   localparam int RANDOM_ITEMS = 1800;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      PAIR_CLOSE,
      PAIR_OPPOSED,
      PAIR_RAIL
   } sample_kind_type;

   typedef enum int {
      MASK_ALL,
      MASK_NONE,
      MASK_MIXED
   } mask_mode_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [SW-1:0]          req_sample_a = '0;
   logic signed [SW-1:0]          req_sample_b = '0;
   logic                          req_in_mask = 1'b0;
   logic                          req_last_sample = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mnrd_pkg::ROOT_BITS-1:0] rsp_nrmsd;
   logic                          rsp_result_valid;
   int                            failures;
   int                            pending;

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit hold_request   = 1'b0;
   int random_items   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   masked_normalized_rms_difference_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_in_mask      (req_in_mask),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_nrmsd        (rsp_nrmsd),
      .rsp_result_valid (rsp_result_valid)
   );

   nrmsd_checker nrmsd_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_in_mask      (req_in_mask),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_nrmsd        (rsp_nrmsd),
      .rsp_result_valid (rsp_result_valid),
      .failures         (failures),
      .pending          (pending)
   );

   function automatic logic signed [SW-1:0] rail_value(input int pick);
      case (pick)
         0: return SW'(-32768);
         1: return SW'(-1);
         2: return SW'(0);
         3: return SW'(1);
         default: return SW'(32767);
      endcase
   endfunction

   task automatic send_sample(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b,
                              input logic in_mask, input logic last);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_a    <= a;
      req_sample_b    <= b;
      req_in_mask     <= in_mask;
      req_last_sample <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_voxel(input int length, input sample_kind_type kind,
                             input mask_mode_type mode);
      logic signed [SW-1:0] a;
      logic signed [SW-1:0] b;
      logic                 in_mask;
      for (int i = 0; i < length; i++) begin
         case (kind)
            SPREAD_FULL: begin
               a = SW'($urandom);
               b = SW'($urandom);
            end
            SPREAD_NARROW: begin
               a = SW'($urandom_range(0, 255) - 128);
               b = SW'($urandom_range(0, 255) - 128);
            end
            PAIR_CLOSE: begin
               a = SW'($urandom);
               b = SW'(a + $urandom_range(0, 64) - 32);
            end
            PAIR_OPPOSED: begin
               // Nearly opposite samples keep the mean sum small.
               a = SW'($urandom);
               b = SW'(-a + $urandom_range(0, 6) - 3);
            end
            default: begin
               a = rail_value($urandom_range(0, 4));
               b = rail_value($urandom_range(0, 4));
            end
         endcase
         case (mode)
            MASK_ALL:  in_mask = 1'b1;
            MASK_NONE: in_mask = 1'b0;
            default:   in_mask = 1'($urandom_range(0, 1));
         endcase
         send_sample(a, b, in_mask, i == length - 1);
         random_items++;
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Result side: a random hold before each item, and one long hold on request.
   initial begin : receiver
      int stall_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall_cycles = 300;
         end else begin
            stall_cycles = receiver_idles ? $urandom_range(0, 4) : 0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int            length;
      int            roll;
      int            voxel_count;
      mask_mode_type mode;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(32767, 32767, 1'b1, 1'b1);
      send_sample(-32768, -32768, 1'b1, 1'b1);
      // The mean rounds down to zero here, so the mean sum stays zero.
      send_sample(32767, -32768, 1'b1, 1'b1);
      send_sample(0, 0, 1'b1, 1'b1);
      // Mean sum of one: difference sums of 196 and 256 sit on either side of saturation.
      send_sample(8, -6, 1'b1, 1'b1);
      send_sample(9, -7, 1'b1, 1'b1);
      send_sample(100, -98, 1'b1, 1'b1);
      send_sample(-32768, 0, 1'b1, 1'b1);
      send_sample(1000, 500, 1'b1, 1'b0);
      send_sample(7, 3, 1'b0, 1'b1);
      send_sample(1000, 900, 1'b1, 1'b0);
      send_sample(-5, -5, 1'b0, 1'b0);
      send_sample(200, -100, 1'b1, 1'b1);
      send_sample(5, 5, 1'b0, 1'b1);
      send_sample(-1, 0, 1'b1, 1'b0);
      send_sample(32767, 0, 1'b1, 1'b0);
      send_sample(-32768, 32767, 1'b0, 1'b0);
      send_sample(-300, -200, 1'b1, 1'b1);
      send_sample(1, -1, 1'b1, 1'b0);
      send_sample(2, 3, 1'b1, 1'b1);
      wait_results_drained();

      random_items = 0;
      voxel_count  = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (voxel_count % 15 == 0) begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
         end
         // The sender waits here once until every outstanding result is back.
         if (voxel_count == 60) begin
            wait_results_drained();
         end
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            length = $urandom_range(1, 12);
         end else if (roll < 95) begin
            length = $urandom_range(13, 60);
         end else begin
            length = $urandom_range(61, 200);
         end
         roll = $urandom_range(0, 99);
         mode = (roll < 80) ? MASK_ALL : (roll < 90) ? MASK_NONE : MASK_MIXED;
         send_voxel(length, sample_kind_type'($urandom_range(0, 4)), mode);
         voxel_count++;
      end
      wait_results_drained();

      // Short voxels back to back against a long result hold fill the voxel queue.
      sender_idles   = 1'b0;
      receiver_idles = 1'b1;
      hold_request   = 1'b1;
      repeat (40) begin
         send_voxel($urandom_range(1, 2), sample_kind_type'($urandom_range(0, 4)), MASK_ALL);
      end
      wait_results_drained();

      repeat (100) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ masked_normalized_rms_difference_unit.f @@
sv/mnrd_pkg.sv
sv/mnrd_front.sv
sv/mnrd_queue.sv
sv/mnrd_back.sv
sv/masked_normalized_rms_difference_unit.sv
sim/nrmsd_checker.sv
sim/testbench.sv
